### sv/swss_pkg.sv
package swss_pkg;

	localparam int PIXEL_W    = 16;
	localparam int WEIGHT_W   = 18;
	localparam int BIAS_W     = 32;
	localparam int RESULT_W   = 48;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 16;
	localparam int KSIZE_W    = 4;
	localparam int STRIDE_W   = 8;
	// dividend width of the remainder unit, covers both row and column origins
	localparam int DIV_W      = 16;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_KERNEL_DEF = 8;

	localparam logic signed [WEIGHT_W-1:0] WEIGHT_RST = 18'sd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT,
		REG_KERNEL_WIDTH,
		REG_KERNEL_HEIGHT,
		REG_STRIDE_X,
		REG_STRIDE_Y,
		REG_PLANE_WEIGHT,
		REG_PLANE_BIAS
	} cfg_idx_t;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} div_stat_t;

endpackage

### sv/strided_window_sum_subsample_core.sv
// a pixel whose window is not complete is only written to the row store and leaves the sequencer idle
// a grid check runs per axis in the shared remainder unit, column then row; an off grid column skips the row check
// an emitted result follows both checks, the window sum at one row store read per cycle, then drain, multiply, output
// throughput: one pixel at a time, ready only while the sequencer is idle
// reset clears counters, sequencer and output valid, registers take their defaults
// the row store holds no reset and needs no clearing pass
module strided_window_sum_subsample_core import swss_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_KERNEL = MAX_KERNEL_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [PIXEL_W-1:0]    s_axis_tdata,   // [15:0] pixel
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [RESULT_W-1:0]   m_axis_tdata,   // [47:0] pooled_value
	output logic                  m_axis_tlast,   // frame_last
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int KCNT_W = $clog2(MAX_KERNEL + 1);
	localparam int SLOT_W = $clog2(MAX_KERNEL);
	localparam int DEPTH  = MAX_WIDTH * MAX_KERNEL;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SUM_W  = PIXEL_W + 2 * $clog2(MAX_KERNEL);
	localparam int PROD_W = WEIGHT_W + SUM_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MODX,
		ST_MODY,
		ST_SUM,
		ST_DRAIN,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [IMG_W_W-1:0]         image_width_q;
	logic [IMG_H_W-1:0]         image_height_q;
	logic [KSIZE_W-1:0]         kernel_width_q;
	logic [KSIZE_W-1:0]         kernel_height_q;
	logic [STRIDE_W-1:0]        stride_x_q;
	logic [STRIDE_W-1:0]        stride_y_q;
	logic signed [WEIGHT_W-1:0] weight_q;
	logic signed [BIAS_W-1:0]   bias_q;

	logic [COL_W:0]        w_eff;
	logic [IMG_H_W-1:0]    h_eff;
	logic [KCNT_W-1:0]     kw_eff;
	logic [KCNT_W-1:0]     kh_eff;
	logic [STRIDE_W-1:0]   sx_eff;
	logic [STRIDE_W-1:0]   sy_eff;

	logic [COL_W-1:0]      col_q;
	logic [IMG_H_W-1:0]    row_q;
	logic [SLOT_W-1:0]     slot_q;

	logic [COL_W-1:0]      x0_q;
	logic [IMG_H_W-1:0]    y0_q;
	logic                  last_q;
	logic [SLOT_W-1:0]     start_slot_q;
	logic [KCNT_W-1:0]     kx_q;
	logic [KCNT_W-1:0]     ky_q;
	logic [SLOT_W-1:0]     rd_slot_q;
	logic                  rd_vld_q;
	logic signed [SUM_W-1:0]    acc_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic [RESULT_W-1:0]        out_data_q;
	logic                       out_last_q;
	logic                       out_vld_q;

	logic signed [PIXEL_W-1:0] store_mem [0:DEPTH-1];
	logic signed [PIXEL_W-1:0] rdata_q;

	logic                  in_acc;
	logic                  cfg_acc;
	logic [COL_W:0]        col_p1;
	logic [IMG_H_W:0]      row_p1;
	logic                  x_ok;
	logic                  y_ok;
	logic [COL_W-1:0]      x0_c;
	logic [IMG_H_W-1:0]    y0_c;
	logic                  last_c;
	logic [SLOT_W-1:0]     start_slot_c;
	logic [SLOT_W-1:0]     slot_next;
	logic [SLOT_W-1:0]     rd_slot_next;
	logic                  kx_last;
	logic                  ky_last;
	logic [ADDR_W-1:0]     waddr;
	logic [ADDR_W-1:0]     raddr;
	logic                  div_start;
	logic [DIV_W-1:0]      div_dividend;
	logic [STRIDE_W-1:0]   div_divisor;
	div_stat_t             div_stat;
	logic                  out_free;

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign cfg_acc       = cfg_valid && cfg_ready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign out_free      = !out_vld_q || m_axis_tready;

	// zero acts as one, oversize image width and kernel sizes clamp to the build limit
	always_comb begin
		if (image_width_q == '0) begin
			w_eff = (COL_W + 1)'(1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			w_eff = (COL_W + 1)'(MAX_WIDTH);
		end else begin
			w_eff = (COL_W + 1)'(image_width_q);
		end
		h_eff = (image_height_q == '0) ? IMG_H_W'(1) : image_height_q;
		if (kernel_width_q == '0) begin
			kw_eff = KCNT_W'(1);
		end else if (32'(kernel_width_q) > MAX_KERNEL) begin
			kw_eff = KCNT_W'(MAX_KERNEL);
		end else begin
			kw_eff = KCNT_W'(kernel_width_q);
		end
		if (kernel_height_q == '0) begin
			kh_eff = KCNT_W'(1);
		end else if (32'(kernel_height_q) > MAX_KERNEL) begin
			kh_eff = KCNT_W'(MAX_KERNEL);
		end else begin
			kh_eff = KCNT_W'(kernel_height_q);
		end
		sx_eff = (stride_x_q == '0) ? STRIDE_W'(1) : stride_x_q;
		sy_eff = (stride_y_q == '0) ? STRIDE_W'(1) : stride_y_q;
	end

	// window origin and frame end for the pixel being accepted
	always_comb begin
		int ss;
		col_p1 = {1'b0, col_q} + 1'b1;
		row_p1 = {1'b0, row_q} + 1'b1;
		x_ok   = 32'(col_p1) >= 32'(kw_eff);
		y_ok   = 32'(row_p1) >= 32'(kh_eff);
		x0_c   = COL_W'(32'(col_p1) - 32'(kw_eff));
		y0_c   = IMG_H_W'(32'(row_p1) - 32'(kh_eff));
		last_c = (32'(x0_c) + 32'(sx_eff) + 32'(kw_eff) > 32'(w_eff))
			&& (32'(y0_c) + 32'(sy_eff) + 32'(kh_eff) > 32'(h_eff));
		// slot of the top window row, current slot minus kh-1 modulo the store rows
		ss = 32'(slot_q) + MAX_KERNEL + 1 - 32'(kh_eff);
		start_slot_c = (ss >= MAX_KERNEL) ? SLOT_W'(ss - MAX_KERNEL) : SLOT_W'(ss);
		slot_next = (32'(slot_q) == MAX_KERNEL - 1) ? '0 : slot_q + 1'b1;
		rd_slot_next = (32'(rd_slot_q) == MAX_KERNEL - 1) ? '0 : rd_slot_q + 1'b1;
		kx_last = (32'(kx_q) + 1) == 32'(kw_eff);
		ky_last = (32'(ky_q) + 1) == 32'(kh_eff);
		waddr = ADDR_W'(32'(slot_q) * MAX_WIDTH + 32'(col_q));
		raddr = ADDR_W'(32'(rd_slot_q) * MAX_WIDTH + 32'(x0_q) + 32'(kx_q));
	end

	assign div_start = (state_q == ST_IDLE && in_acc && x_ok && y_ok)
		|| (state_q == ST_MODX && div_stat.done && div_stat.rem_zero);
	assign div_dividend = (state_q == ST_IDLE) ? DIV_W'(x0_c) : DIV_W'(y0_q);
	assign div_divisor  = (state_q == ST_IDLE) ? sx_eff : sy_eff;

	swss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			store_mem[waddr] <= s_axis_tdata;
		end
		rdata_q <= store_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= IMG_W_W'(1);
			image_height_q  <= IMG_H_W'(1);
			kernel_width_q  <= KSIZE_W'(1);
			kernel_height_q <= KSIZE_W'(1);
			stride_x_q      <= STRIDE_W'(1);
			stride_y_q      <= STRIDE_W'(1);
			weight_q        <= WEIGHT_RST;
			bias_q          <= '0;
		end else if (cfg_acc) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_IMAGE_WIDTH:   image_width_q   <= cfg_data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data[IMG_H_W-1:0];
				REG_KERNEL_WIDTH:  kernel_width_q  <= cfg_data[KSIZE_W-1:0];
				REG_KERNEL_HEIGHT: kernel_height_q <= cfg_data[KSIZE_W-1:0];
				REG_STRIDE_X:      stride_x_q      <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_Y:      stride_y_q      <= cfg_data[STRIDE_W-1:0];
				REG_PLANE_WEIGHT:  weight_q        <= cfg_data[WEIGHT_W-1:0];
				REG_PLANE_BIAS:    bias_q          <= cfg_data[BIAS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			col_q        <= '0;
			row_q        <= '0;
			slot_q       <= '0;
			x0_q         <= '0;
			y0_q         <= '0;
			last_q       <= 1'b0;
			start_slot_q <= '0;
			kx_q         <= '0;
			ky_q         <= '0;
			rd_slot_q    <= '0;
			rd_vld_q     <= 1'b0;
			acc_q        <= '0;
			prod_q       <= '0;
			out_data_q   <= '0;
			out_last_q   <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			rd_vld_q <= (state_q == ST_SUM);
			if (rd_vld_q) begin
				acc_q <= acc_q + SUM_W'(rdata_q);
			end
			if (state_q == ST_OUT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						x0_q         <= x0_c;
						y0_q         <= y0_c;
						last_q       <= last_c;
						start_slot_q <= start_slot_c;
						if (32'(col_p1) >= 32'(w_eff)) begin
							col_q <= '0;
							if (32'(row_p1) >= 32'(h_eff)) begin
								row_q  <= '0;
								slot_q <= '0;
							end else begin
								row_q  <= row_p1[IMG_H_W-1:0];
								slot_q <= slot_next;
							end
						end else begin
							col_q <= col_p1[COL_W-1:0];
						end
						if (x_ok && y_ok) begin
							state_q <= ST_MODX;
						end
					end
				end
				ST_MODX: begin
					if (div_stat.done) begin
						state_q <= div_stat.rem_zero ? ST_MODY : ST_IDLE;
					end
				end
				ST_MODY: begin
					if (div_stat.done) begin
						if (div_stat.rem_zero) begin
							state_q   <= ST_SUM;
							acc_q     <= '0;
							kx_q      <= '0;
							ky_q      <= '0;
							rd_slot_q <= start_slot_q;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SUM: begin
					// one store read issued per cycle, row by row through the window
					if (kx_last) begin
						kx_q      <= '0;
						ky_q      <= ky_q + 1'b1;
						rd_slot_q <= rd_slot_next;
						if (ky_last) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						kx_q <= kx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q  <= weight_q * acc_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_data_q <= RESULT_W'(prod_q) + RESULT_W'(bias_q);
						out_last_q <= last_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/swss_div.sv
module swss_div import swss_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_W-1:0]    dividend,
	input  logic [STRIDE_W-1:0] divisor,
	output div_stat_t           stat
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0]    dvd_q;
	logic [STRIDE_W-1:0] dsr_q;
	logic [STRIDE_W-1:0] rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic [STRIDE_W:0]   trial;
	logic [STRIDE_W:0]   diff;

	// restoring remainder, one dividend bit per cycle
	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q <= dividend;
				dsr_q <= divisor;
				rem_q <= '0;
				cnt_q <= CNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
				rem_q <= (trial >= {1'b0, dsr_q}) ? diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.done     = done_q;
	assign stat.rem_zero = (rem_q == '0);

endmodule

### sv/swss_checker.sv
module swss_checker import swss_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [RESULT_W-1:0]   m_axis_tdata,
	input logic                  m_axis_tlast,
	input logic                  cfg_valid,
	input logic                  cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// a new result comes only after the multiply and load steps with input closed
	a_out_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready) && $past(!s_axis_tready, 2))
		else $error("result appeared without a busy sequencer");

	// an accepted pixel never produces a result in the next cycle
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result too early after a request");

	// register writes are never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

endmodule

bind strided_window_sum_subsample_core swss_checker u_swss_checker (.*);
